// ===== rtl/core/lffr_pkg.sv =====
package lffr_pkg;

	// Buffer size in bytes and the resulting frame length bound
	localparam int FRAME_BUFFER = 256;
	localparam int FRAME_LIMIT  = (FRAME_BUFFER < 256) ? FRAME_BUFFER : 256;

	// Frame layout
	localparam logic [7:0] LEN_OFFSET     = 8'd4;
	localparam logic [7:0] FRAME_OVERHEAD = 8'd7;
	localparam logic [7:0] LAST_FROM_LEN  = 8'd6;

	// Register reset values
	localparam logic [7:0] START_BYTE_RST = 8'hBB;
	localparam logic [7:0] END_BYTE_RST   = 8'h7E;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd1;

	typedef enum logic [2:0] {
		ST_DISCARD  = 3'd0,
		ST_IN_FRAME = 3'd1,
		ST_GOOD     = 3'd2,
		ST_BAD_END  = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] position;
		status_t    status;
		logic       last;
	} result_t;

endpackage

// ===== rtl/core/lffr_cfg.sv =====
module lffr_cfg import lffr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte   <= END_BYTE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_BYTE: cfg_q.start_byte <= cfg_wdata;
				REG_END_BYTE:   cfg_q.end_byte   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/lffr_track.sv =====
module lffr_track import lffr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_s1,
	input  cfg_t       cfg,
	output result_t    res,
	output logic       in_frame
);

	logic       in_frame_q;
	logic [7:0] count_q;
	logic [7:0] len_q;

	logic       too_long;
	logic       at_last;
	logic [8:0] last_pos;

	// Oversize check on the length byte and end offset of the current frame
	assign too_long = (11'(rx_s1) + 11'(FRAME_OVERHEAD)) > 11'(FRAME_LIMIT);
	assign last_pos = {1'b0, len_q} + {1'b0, LAST_FROM_LEN};
	assign at_last  = (count_q > LEN_OFFSET) && ({1'b0, count_q} == last_pos);

	// Classify the byte against the frame state
	always_comb begin
		res.data_byte = rx_s1;
		res.position  = 8'd0;
		res.status    = ST_DISCARD;
		res.last      = 1'b0;
		if (!in_frame_q) begin
			if (rx_s1 == cfg.start_byte) begin
				res.status = ST_IN_FRAME;
			end
		end else begin
			res.position = count_q;
			res.status   = ST_IN_FRAME;
			if (count_q == LEN_OFFSET) begin
				if (too_long) begin
					res.status = ST_TOO_LONG;
					res.last   = 1'b1;
				end
			end else if (at_last) begin
				res.status = (rx_s1 == cfg.end_byte) ? ST_GOOD : ST_BAD_END;
				res.last   = 1'b1;
			end
		end
	end

	// Advance the frame state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= 8'd0;
			len_q      <= 8'd0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_s1 == cfg.start_byte) begin
					in_frame_q <= 1'b1;
					count_q    <= 8'd1;
					len_q      <= 8'd0;
				end
			end else begin
				if (count_q == LEN_OFFSET) begin
					len_q <= rx_s1;
				end
				if (res.last) begin
					in_frame_q <= 1'b0;
					count_q    <= 8'd0;
				end else begin
					count_q <= count_q + 8'd1;
				end
			end
		end
	end

	assign in_frame = in_frame_q;

endmodule

// ===== rtl/core/length_field_frame_receiver_core.sv =====
// Start byte / length field frame receiver.
// Input channel: in_valid, in_stall, rx_byte - one received byte per item.
// Output channel: out_valid, out_stall and data_byte, position, status,
// frame_last - exactly one result item per input item, in order.
// Configuration: cfg_we, cfg_index, cfg_wdata; index 0 is the start byte,
// index 1 the end marker. Write only while no item is in flight.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the frame
// state update is a single compare-and-count step between the input and result registers.
// A stalled output holds its item; the input register still takes one
// more item, and in_stall rises only when that register is also full.
// Reset: both registers empty, receiver idle, start byte 0xBB, end 0x7E.
module length_field_frame_receiver_core import lffr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           data_byte,
	output logic [7:0]           position,
	output logic [2:0]           status,
	output logic                 frame_last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_q;
	logic       valid_s1;
	logic [7:0] rx_s1;
	logic       out_valid_q;
	logic       adv;
	logic       take;
	logic       in_frame;

	lffr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lffr_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.rx_s1    (rx_s1),
		.cfg      (cfg),
		.res      (res),
		.in_frame (in_frame)
	);

	// Move the input register into the result register when it is free
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rx_s1 <= rx_byte;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = res_q.data_byte;
	assign position   = res_q.position;
	assign status     = res_q.status;
	assign frame_last = res_q.last;

`ifndef SYNTH
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |->
			(status == ST_GOOD || status == ST_BAD_END || status == ST_TOO_LONG))
		else $error("frame_last with a non-terminal status");

	a_discard_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DISCARD |-> position == 8'd0 && !frame_last)
		else $error("discarded byte with position or frame_last set");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.last |=> !in_frame)
		else $error("receiver still in frame after the frame ended");
`endif

endmodule
